// File: rtl/text_console_cursor_scroll_defines.svh
// Assertion macros for the text console checker.
`ifndef TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_SCROLL_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("text console check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("text console check failed");

`endif

// File: rtl/tcc_pkg.sv
// Shared types and constants of the text console.
`timescale 1ns / 1ps
`default_nettype none

package tcc_pkg;

    localparam int CHAR_W = 8;
    localparam int ROW_W  = 4;
    localparam int COL_W  = 5;

    // control codes
    localparam logic [CHAR_W-1:0] CODE_LF = 8'd10;
    localparam logic [CHAR_W-1:0] CODE_CR = 8'd13;

    // item modes
    localparam logic MODE_PUT  = 1'b0;
    localparam logic MODE_READ = 1'b1;

    typedef struct packed {
        logic              mode;
        logic [CHAR_W-1:0] char_code;
        logic [ROW_W-1:0]  read_row;
        logic [COL_W-1:0]  read_col;
    } t_item;

    typedef struct packed {
        logic [CHAR_W-1:0] cell_data;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic              scrolled;
    } t_result;

endpackage

`default_nettype wire

// File: rtl/tcc_addr.sv
// Shared cell address unit: row times row pitch plus offset.
`timescale 1ns / 1ps
`default_nettype none

module tcc_addr #(
    parameter int COLUMNS = 32,
    parameter int ROWS    = 10
) (
    input  wire logic [$clog2(ROWS+1)-1:0]         i_row,
    input  wire logic [$clog2(ROWS*COLUMNS+1)-1:0] i_off,
    output logic      [$clog2(ROWS*COLUMNS)-1:0]   o_addr
);

    localparam int AW = $clog2(ROWS * COLUMNS);

    // constant multiply by the row pitch, then one add
    assign o_addr = AW'(32'(i_row) * COLUMNS + 32'(i_off));

endmodule

`default_nettype wire

// File: rtl/tcc_mem.sv
// Cell store: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none

module tcc_mem #(
    parameter int DEPTH = 320
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [tcc_pkg::CHAR_W-1:0] i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [tcc_pkg::CHAR_W-1:0] o_rdata
);

    logic [tcc_pkg::CHAR_W-1:0] r_mem [DEPTH];
    logic [tcc_pkg::CHAR_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/tcc_ctrl.sv
// Sequencer: cursor, clearing pass, row scroll and result register.
`timescale 1ns / 1ps
`default_nettype none

module tcc_ctrl #(
    parameter int COLUMNS = 32,
    parameter int ROWS    = 10
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_start,
    input  wire tcc_pkg::t_item                       i_item,
    output logic                                      o_busy,
    output logic                                      o_valid,
    output tcc_pkg::t_result                          o_result,
    output logic                                      o_we,
    output logic      [$clog2(ROWS*COLUMNS)-1:0]      o_waddr,
    output logic      [tcc_pkg::CHAR_W-1:0]           o_wdata,
    output logic      [$clog2(ROWS*COLUMNS)-1:0]      o_raddr,
    input  wire logic [tcc_pkg::CHAR_W-1:0]           i_rdata
);

    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int RW    = $clog2(ROWS + 1);
    localparam int CW    = $clog2(COLUMNS + 1);
    localparam int SCR_N = (ROWS - 1) * COLUMNS;

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_CLEAR  = 5'b00010,
        S_RDW    = 5'b00100,
        S_SCROLL = 5'b01000,
        S_DRAIN  = 5'b10000
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [AW-1:0]         r_wa, n_wa;
    logic                  r_wv, n_wv;
    logic [RW-1:0]         r_row, n_row;
    logic [CW-1:0]         r_col, n_col;
    logic                  r_rd_ok, n_rd_ok;
    logic                  r_valid, n_valid;
    tcc_pkg::t_result      r_res, n_res;

    logic                  accept;
    logic                  rd_ok;
    logic                  printable;
    logic [RW-1:0]         put_row;
    logic [CW-1:0]         put_col;
    logic                  put_scroll;
    logic [RW-1:0]         op_row;
    logic [CNT_W-1:0]      op_off;
    logic [AW-1:0]         addr;

    assign accept = i_start && (r_state == S_IDLE);
    assign rd_ok  = (32'(i_item.read_row) < ROWS) && (32'(i_item.read_col) < COLUMNS);
    assign printable = (i_item.char_code != tcc_pkg::CODE_LF)
                    && (i_item.char_code != tcc_pkg::CODE_CR);

    // cursor after a put item
    always_comb begin
        put_row    = r_row;
        put_col    = r_col;
        put_scroll = 1'b0;
        if (i_item.char_code == tcc_pkg::CODE_LF) begin
            put_row = r_row + 1'b1;
        end else if (i_item.char_code == tcc_pkg::CODE_CR) begin
            put_col = '0;
        end else begin
            put_col = r_col + 1'b1;
        end
        if (put_col == CW'(COLUMNS)) begin
            put_col = '0;
            put_row = put_row + 1'b1;
        end
        if (put_row == RW'(ROWS)) begin
            put_row    = RW'(ROWS - 1);
            put_scroll = 1'b1;
        end
    end

    // operands of the shared address unit
    always_comb begin
        if (r_state == S_SCROLL) begin
            op_row = RW'(1);
            op_off = r_cnt;
        end else if (i_item.mode == tcc_pkg::MODE_READ) begin
            op_row = RW'(i_item.read_row);
            op_off = CNT_W'(i_item.read_col);
        end else begin
            op_row = r_row;
            op_off = CNT_W'(r_col);
        end
    end

    tcc_addr #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_addr (
        .i_row  (op_row),
        .i_off  (op_off),
        .o_addr (addr)
    );

    // store write port selection
    always_comb begin
        o_we    = 1'b0;
        o_waddr = addr;
        o_wdata = i_item.char_code;
        unique case (r_state)
            S_CLEAR: begin
                o_we    = 1'b1;
                o_waddr = r_cnt[AW-1:0];
                o_wdata = '0;
            end
            S_IDLE: begin
                o_we = accept && (i_item.mode == tcc_pkg::MODE_PUT) && printable;
            end
            S_SCROLL: begin
                o_we    = r_wv;
                o_waddr = r_wa;
                o_wdata = i_rdata;
            end
            S_DRAIN: begin
                o_we    = 1'b1;
                o_waddr = r_wa;
                o_wdata = i_rdata;
            end
            S_RDW: begin
                o_we = 1'b0;
            end
            default: begin
                o_we = 1'b0;
            end
        endcase
    end

    assign o_raddr = addr;

    // sequencer
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_wa    = r_wa;
        n_wv    = r_wv;
        n_row   = r_row;
        n_col   = r_col;
        n_rd_ok = r_rd_ok;
        n_valid = 1'b0;
        n_res   = r_res;
        unique case (r_state)
            S_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    if (i_item.mode == tcc_pkg::MODE_READ) begin
                        n_rd_ok = rd_ok;
                        n_state = S_RDW;
                    end else begin
                        n_row = put_row;
                        n_col = put_col;
                        if (put_scroll) begin
                            n_state = S_SCROLL;
                            n_cnt   = '0;
                            n_wv    = 1'b0;
                        end else begin
                            n_valid            = 1'b1;
                            n_res.cell_data    = '0;
                            n_res.cursor_row   = tcc_pkg::ROW_W'(put_row);
                            n_res.cursor_col   = tcc_pkg::COL_W'(put_col);
                            n_res.scrolled     = 1'b0;
                        end
                    end
                end
            end
            S_RDW: begin
                n_valid          = 1'b1;
                n_res.cell_data  = r_rd_ok ? i_rdata : '0;
                n_res.cursor_row = tcc_pkg::ROW_W'(r_row);
                n_res.cursor_col = tcc_pkg::COL_W'(r_col);
                n_res.scrolled   = 1'b0;
                n_state          = S_IDLE;
            end
            S_SCROLL: begin
                // read one row ahead, write back in the next cycle
                n_wa  = r_cnt[AW-1:0];
                n_wv  = 1'b1;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SCR_N - 1)) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_valid          = 1'b1;
                n_res.cell_data  = '0;
                n_res.cursor_row = tcc_pkg::ROW_W'(r_row);
                n_res.cursor_col = tcc_pkg::COL_W'(r_col);
                n_res.scrolled   = 1'b1;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
            r_wv    <= 1'b0;
            r_row   <= '0;
            r_col   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_wv    <= n_wv;
            r_row   <= n_row;
            r_col   <= n_col;
            r_valid <= n_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_wa    <= n_wa;
        r_rd_ok <= n_rd_ok;
        r_res   <= n_res;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

`default_nettype wire

// File: rtl/text_console_cursor_scroll.sv
// Top level of the text console with cursor and row scroll.
//
// Usage: an item is taken at a clock edge where start is high and busy is
// low. i_item.mode selects put (store char_code at the cursor, LF moves down,
// CR returns to column 0) or read (fetch the cell at read_row/read_col).
// Every item gives one result on o_result, marked by o_valid for exactly
// one cycle; the receiver cannot stall, each result must be taken then.
// Result and busy per item mode:
//   put without scroll : result the cycle after accept, busy stays low,
//                        one item per cycle
//   read               : busy in S_RDW, which registers the stored cell as result
//   put with scroll    : busy in S_SCROLL and S_DRAIN, the single store
//                        write port copying one cell per cycle
// Reset: cursor goes to row 0, column 0, then a clearing pass writes zero to
// all ROWS*COLUMNS cells, one per cycle, with busy high.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_scroll #(
    parameter int COLUMNS = 32,
    parameter int ROWS    = 10
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire tcc_pkg::t_item   i_item,
    output logic                  o_valid,
    output tcc_pkg::t_result      o_result
);

    localparam int DEPTH = ROWS * COLUMNS;
    localparam int AW    = $clog2(DEPTH);

    logic                        we;
    logic [AW-1:0]               waddr;
    logic [tcc_pkg::CHAR_W-1:0]  wdata;
    logic [AW-1:0]               raddr;
    logic [tcc_pkg::CHAR_W-1:0]  rdata;

    tcc_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_item   (i_item),
        .o_busy   (busy),
        .o_valid  (o_valid),
        .o_result (o_result),
        .o_we     (we),
        .o_waddr  (waddr),
        .o_wdata  (wdata),
        .o_raddr  (raddr),
        .i_rdata  (rdata)
    );

    tcc_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

`default_nettype wire

// File: rtl/tcc_checker.sv
// Port-level checks of the text console, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "text_console_cursor_scroll_defines.svh"

module tcc_checker #(
    parameter int COLUMNS = 32,
    parameter int ROWS    = 10
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             start,
    input wire logic             busy,
    input wire tcc_pkg::t_item   i_item,
    input wire logic             o_valid,
    input wire tcc_pkg::t_result o_result
);

    logic read_acc;
    logic read_oob;

    assign read_acc = start && !busy && (i_item.mode == tcc_pkg::MODE_READ);
    assign read_oob = (32'(i_item.read_row) >= ROWS) || (32'(i_item.read_col) >= COLUMNS);

    // a scroll leaves the cursor on the bottom row
    `TCC_ASSERT_NOW(a_scroll_row, i_clk, i_rst_n, o_valid && o_result.scrolled,
        o_result.cursor_row == tcc_pkg::ROW_W'(ROWS - 1))

    // a scroll result only follows a busy copy phase
    `TCC_ASSERT_NOW(a_scroll_busy, i_clk, i_rst_n, o_valid && o_result.scrolled, $past(busy))

    // a read keeps busy high after accept, then returns its result
    `TCC_ASSERT_NXT(a_read_busy, i_clk, i_rst_n, read_acc, busy ##1 o_valid && !o_result.scrolled)

    // an out-of-range read returns zero
    `TCC_ASSERT_NXT(a_read_oob, i_clk, i_rst_n, read_acc && read_oob,
        ##1 (o_result.cell_data == '0))

endmodule

bind text_console_cursor_scroll tcc_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcc_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_item   (i_item),
    .o_valid  (o_valid),
    .o_result (o_result)
);

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for the text console with cursor and row scroll.
`timescale 1ns / 1ps

module tb;

    localparam int COLUMNS    = 32;
    localparam int ROWS       = 10;
    localparam int CLK_PERIOD = 20;
    localparam int TAIL_WAIT  = 16;
    localparam int RAND_ITEMS = 1250;

    // Console shadow: predicts cursor, scroll and cell reads, holds pending results
    class console_scoreboard;
        logic [tcc_pkg::CHAR_W-1:0] cells [ROWS*COLUMNS];
        int unsigned                cur_row;
        int unsigned                cur_col;
        tcc_pkg::t_result           pending_results[$];
        int unsigned                fail_count;

        function void clear_state();
            foreach (cells[i]) cells[i] = '0;
            cur_row    = 0;
            cur_col    = 0;
            fail_count = 0;
            pending_results.delete();
        endfunction

        // apply one accepted transaction and queue its expected result
        function void note_item(tcc_pkg::t_item it);
            tcc_pkg::t_result res;
            int unsigned      i;
            res = '0;
            if (it.mode == tcc_pkg::MODE_READ) begin
                if (it.read_row < ROWS && it.read_col < COLUMNS)
                    res.cell_data = cells[it.read_row*COLUMNS + it.read_col];
            end else begin
                if (it.char_code == tcc_pkg::CODE_LF) begin
                    cur_row++;
                end else if (it.char_code == tcc_pkg::CODE_CR) begin
                    cur_col = 0;
                end else begin
                    cells[cur_row*COLUMNS + cur_col] = it.char_code;
                    cur_col++;
                end
                if (cur_col >= COLUMNS) begin
                    cur_col = 0;
                    cur_row++;
                end
                // scroll: rows 1..ROWS-1 move up, bottom row keeps its contents
                if (cur_row >= ROWS) begin
                    for (i = 0; i < (ROWS-1)*COLUMNS; i++)
                        cells[i] = cells[i + COLUMNS];
                    cur_row      = ROWS - 1;
                    res.scrolled = 1'b1;
                end
            end
            res.cursor_row = tcc_pkg::ROW_W'(cur_row);
            res.cursor_col = tcc_pkg::COL_W'(cur_col);
            pending_results.push_back(res);
        endfunction

        function int unsigned pending_count();
            return pending_results.size();
        endfunction

        // compare one result from the block with the oldest expectation
        function void check_result(tcc_pkg::t_result got);
            tcc_pkg::t_result want;
            if (pending_results.size() == 0) begin
                if (fail_count < 10)
                    $display("%0t: result with nothing pending: data=%0d row=%0d col=%0d scr=%0d",
                             $time, got.cell_data, got.cursor_row, got.cursor_col,
                             got.scrolled);
                fail_count++;
                return;
            end
            want = pending_results.pop_front();
            if (got.cell_data  !== want.cell_data  || got.cursor_row !== want.cursor_row ||
                got.cursor_col !== want.cursor_col || got.scrolled   !== want.scrolled) begin
                if (fail_count < 10) begin
                    $display("%0t: mismatch cell_data exp %0d got %0d, cursor_row exp %0d got %0d",
                             $time, want.cell_data, got.cell_data,
                             want.cursor_row, got.cursor_row);
                    $display("    cursor_col exp %0d got %0d, scrolled exp %0d got %0d",
                             want.cursor_col, got.cursor_col, want.scrolled, got.scrolled);
                end
                fail_count++;
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    tcc_pkg::t_item   i_item;
    logic             o_valid;
    tcc_pkg::t_result o_result;

    console_scoreboard sb = new();

    text_console_cursor_scroll #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD/2) i_clk = ~i_clk;
    end

    // result monitor: every strobed result is taken in its single cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            sb.check_result(o_result);
    end

    // present one transaction, optionally after a random idle gap
    task automatic send_item(input tcc_pkg::t_item it, input bit allow_idle);
        int gap;
        gap = 0;
        if (allow_idle && $urandom_range(99) < 19)
            gap = ($urandom_range(9) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 8);
        repeat (gap) begin
            @(negedge i_clk);
            start <= 1'b0;
        end
        @(negedge i_clk);
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        sb.note_item(it);
    endtask

    task automatic put_char(input logic [tcc_pkg::CHAR_W-1:0] code);
        tcc_pkg::t_item it;
        it           = '0;
        it.mode      = tcc_pkg::MODE_PUT;
        it.char_code = code;
        it.read_row  = tcc_pkg::ROW_W'($urandom);
        it.read_col  = tcc_pkg::COL_W'($urandom);
        send_item(it, 1'b1);
    endtask

    task automatic read_cell(input logic [tcc_pkg::ROW_W-1:0] r,
                             input logic [tcc_pkg::COL_W-1:0] c);
        tcc_pkg::t_item it;
        it           = '0;
        it.mode      = tcc_pkg::MODE_READ;
        it.char_code = tcc_pkg::CHAR_W'($urandom);
        it.read_row  = r;
        it.read_col  = c;
        send_item(it, 1'b1);
    endtask

    // stimulus and end of run
    initial begin
        tcc_pkg::t_item it;
        int             pick;
        sb.clear_state();
        i_rst_n = 1'b0;
        start   = 1'b0;
        i_item  = '0;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: null and top codes, CR, LF, reads in and out of range, scroll
        put_char(8'd0);
        put_char(8'd255);
        put_char(8'h41);
        read_cell(4'd0, 5'd0);
        read_cell(4'd0, 5'd1);
        put_char(tcc_pkg::CODE_CR);
        put_char(8'h7f);
        put_char(tcc_pkg::CODE_LF);
        read_cell(4'd0, 5'd0);
        read_cell(4'd9, 5'd31);
        read_cell(4'd15, 5'd31);
        read_cell(4'd10, 5'd0);
        repeat (9) put_char(tcc_pkg::CODE_LF);
        read_cell(4'd0, 5'd0);
        read_cell(4'd8, 5'd1);

        // random: mostly text with line control, reads across the whole store
        for (int n = 0; n < RAND_ITEMS; n++) begin
            it           = '0;
            it.char_code = tcc_pkg::CHAR_W'($urandom);
            it.read_row  = tcc_pkg::ROW_W'($urandom_range(0, ROWS-1));
            it.read_col  = tcc_pkg::COL_W'($urandom);
            pick         = $urandom_range(99);
            if (pick < 30) begin
                it.mode = tcc_pkg::MODE_READ;
                if ($urandom_range(9) == 0)
                    it.read_row = tcc_pkg::ROW_W'($urandom_range(ROWS, 15));
            end else begin
                it.mode = tcc_pkg::MODE_PUT;
                if ($urandom_range(9) == 0)
                    it.read_row = tcc_pkg::ROW_W'($urandom);
                if (pick < 36)
                    it.char_code = tcc_pkg::CODE_LF;
                else if (pick < 41)
                    it.char_code = tcc_pkg::CODE_CR;
            end
            // long stretch with back-to-back transactions
            send_item(it, !(n >= 500 && n < 800));
        end
        @(negedge i_clk);
        start <= 1'b0;

        while (sb.pending_count() != 0)
            @(posedge i_clk);
        repeat (TAIL_WAIT) @(posedge i_clk);

        if (sb.fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // watchdog
    initial begin
        #(64'd4_000_000 * CLK_PERIOD);
        $display("Some tests failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/tcc_pkg.sv
rtl/tcc_addr.sv
rtl/tcc_mem.sv
rtl/tcc_ctrl.sv
rtl/text_console_cursor_scroll.sv
rtl/tcc_checker.sv
tb/tb.sv
